// ===== rtl/core/modular_exponentiation_macros.svh =====
// Assertion helpers shared by the core.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

    localparam int FIELD_W   = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;

    localparam logic [FIELD_W-1:0] MODULUS_RESET  = 64'd1;
    localparam logic [FIELD_W-1:0] EXPONENT_RESET = 64'd65537;

    // status of a bit-serial modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// Each word: the base is reduced mod m, then one square-and-multiply step runs per exponent
// bit, LSB first, up to the highest set bit, so the run grows with the exponent's length.
// One word at a time: a new word is taken only in idle, after the last result is in the output
// register; the two bit-serial multipliers set the pace. Modulus zero gives a zero result.
// Reset: aresetn, synchronous, active low; modulus resets to 1, exponent to 65537.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_base,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FIELD_W-1:0]   m_result,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int MB = MOD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,   // base mod m, computed as (1 mod m) * base
        ST_LAUNCH,   // start next exponent bit, or finish when exponent is used up
        ST_STEP,     // square a, and multiply r by a when the bit is set
        ST_FINISH    // wait for the output register
    } state_t;

    state_t        state_reg;
    logic [MB-1:0] modulus_reg;
    logic [MB-1:0] exponent_reg;
    logic [MB-1:0] e_reg;        // remaining exponent bits, LSB next
    logic [MB-1:0] a_reg;        // running power of the base
    logic [MB-1:0] r_reg;        // running result
    logic          m_valid_reg;
    logic [FIELD_W-1:0] m_result_reg;

    logic          accept;
    logic          m_zero;
    logic [MB-1:0] one_m;

    logic          a_start;
    logic [MB-1:0] a_x;
    logic [MB-1:0] a_y;
    logic [MB-1:0] a_res;
    mm_status_t    a_st;

    logic          r_start;
    logic [MB-1:0] r_res;
    mm_status_t    r_st;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    assign m_zero = (modulus_reg == '0);
    assign one_m  = (modulus_reg == MB'(1)) ? '0 : MB'(1);

    // unit A: reduction first, then squaring; unit R: result updates
    assign a_start = (accept && !m_zero) || (state_reg == ST_LAUNCH && e_reg != '0);
    assign a_x     = (state_reg == ST_IDLE) ? one_m : a_reg;
    assign a_y     = (state_reg == ST_IDLE) ? s_base[MB-1:0] : a_reg;
    assign r_start = (state_reg == ST_LAUNCH) && e_reg[0];

    mexp_mulmod #(.W(MB)) u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (a_start),
        .op_x    (a_x),
        .op_y    (a_y),
        .op_m    (modulus_reg),
        .result  (a_res),
        .status  (a_st)
    );

    mexp_mulmod #(.W(MB)) u_mul_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (r_start),
        .op_x    (r_reg),
        .op_y    (a_reg),
        .op_m    (modulus_reg),
        .result  (r_res),
        .status  (r_st)
    );

    // Config registers; out-of-range indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MODULUS_RESET[MB-1:0];
            exponent_reg <= EXPONENT_RESET[MB-1:0];
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data[MB-1:0];
                CFG_EXPONENT: exponent_reg <= cfg_data[MB-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_FINISH the output register is handled below
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        e_reg <= exponent_reg;
                        if (m_zero) begin
                            // no reduction defined: result is zero
                            r_reg     <= '0;
                            state_reg <= ST_FINISH;
                        end else begin
                            r_reg     <= one_m;
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (a_st.done) begin
                        a_reg     <= a_res;
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    if (e_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    // both units run the same length, so A's done covers R
                    if (a_st.done) begin
                        a_reg <= a_res;
                        if (e_reg[0]) begin
                            r_reg <= r_res;
                        end
                        e_reg     <= e_reg >> 1;
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= FIELD_W'(r_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Assertions
    `MEXP_ASSERT_NOW(a_idle_when_ready, aclk, aresetn, s_ready, !a_st.busy, "unit A busy while idle")
    `MEXP_ASSERT_NOW(r_done_with_a, aclk, aresetn, r_st.done, a_st.done, "units out of step")
    `MEXP_ASSERT_NEXT(busy_after_accept, aclk, aresetn, accept, !s_ready, "ready right after accept")

endmodule

// ===== rtl/core/mexp_mulmod.sv =====
// Bit-serial x*y mod m, multiplier bits MSB first.
// Per bit: double, then conditional add of x. Needs x < m.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] op_x,
    input  logic [W-1:0] op_y,
    input  logic [W-1:0] op_m,
    output logic [W-1:0] result,
    output mm_status_t   status
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  m_reg;
    logic [CW-1:0] cnt_reg;
    logic          phase_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W-1:0]  add_b;
    logic [W:0]    sum;
    logic          ge;
    logic [W-1:0]  red;

    // one modular add per cycle: acc + acc, or acc + x
    always_comb begin
        add_b = phase_reg ? x_reg : acc_reg;
        sum   = {1'b0, acc_reg} + {1'b0, add_b};
        ge    = sum >= {1'b0, m_reg};
        red   = ge ? W'(sum - {1'b0, m_reg}) : sum[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end else if (busy_reg) begin
                phase_reg <= ~phase_reg;
                if (phase_reg) begin
                    if (cnt_reg == CW'(W - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            x_reg   <= op_x;
            y_reg   <= op_y;
            m_reg   <= op_m;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_reg <= red;
            end else begin
                if (y_reg[W-1]) begin
                    acc_reg <= red;
                end
                y_reg <= {y_reg[W-2:0], 1'b0};
            end
        end
    end

    assign result      = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
